// ----- sv/clns_pkg.sv -----
// Shared types and constants for the character LCD nibble sequencer.
// No dependencies; every other file of the block refers to this package.
`default_nettype none
package clns_pkg;

	typedef enum logic [1:0] {
		OP_STARTUP = 2'd0,
		OP_COMMAND = 2'd1,
		OP_DATA    = 2'd2,
		OP_STRING  = 2'd3
	} op_t;

	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 8;
	localparam int POS_W     = 6;
	localparam int NIB_IDX_W = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE_HOLD   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POWER_UP_WAIT = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_LINE   = 8'd3;

	localparam logic [7:0] RST_POWER_UP_WAIT = 8'd20;
	localparam logic [POS_W-1:0] RST_LINE_LENGTH = 6'd16;
	localparam logic [7:0] RST_SECOND_LINE = 8'hC0;

	localparam logic [POS_W-1:0] POS_MAX = 6'd63;
	localparam logic [7:0] STARTUP_SECOND_WAIT_MS = 8'd1;
	localparam logic [7:0] STARTUP_CMDS [4] = '{8'h33, 8'h32, 8'h0C, 8'h01};

	localparam logic [NIB_IDX_W-1:0] NIB_LAST_STARTUP = 3'd7;
	localparam logic [NIB_IDX_W-1:0] NIB_LAST_BREAK   = 3'd3;
	localparam logic [NIB_IDX_W-1:0] NIB_LAST_BYTE    = 3'd1;

	typedef struct packed {
		logic [7:0]       power_up_wait_ms;
		logic [POS_W-1:0] line_length;
		logic [7:0]       second_line_command;
	} cfg_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] byte_value;
		logic       line_break;
	} desc_t;

endpackage
`default_nettype wire

// ----- sv/clns_ifs.sv -----
// Channel interfaces of the nibble sequencer: requests, nibble results, register writes.
// Depends on clns_pkg for widths.
`default_nettype none
interface clns_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] byte_value;
	logic       string_start;
	modport source (output valid, op, byte_value, string_start, input ready);
	modport sink (input valid, op, byte_value, string_start, output ready);
endinterface

interface clns_res_if;
	logic       valid;
	logic       ready;
	logic       rs;
	logic [3:0] nibble;
	logic [7:0] wait_before_ms;
	logic       last;
	modport source (output valid, rs, nibble, wait_before_ms, last, input ready);
	modport sink (input valid, rs, nibble, wait_before_ms, last, output ready);
endinterface

interface clns_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [clns_pkg::CFG_IDX_W-1:0] index;
	logic [clns_pkg::CFG_DAT_W-1:0] value;
	modport source (output valid, index, value, input ready);
	modport sink (input valid, index, value, output ready);
endinterface
`default_nettype wire

// ----- sv/clns_front.sv -----
// Front end: accepts requests, tracks the string position and classifies each request.
// Depends on clns_pkg and clns_ifs.
`default_nettype none
module clns_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	clns_req_if.sink                          req,
	input  wire logic [clns_pkg::POS_W-1:0]   line_length,
	input  wire logic                         queue_full,
	output logic                              push,
	output clns_pkg::desc_t                   push_desc
);

	logic [clns_pkg::POS_W-1:0] pos_q;
	logic [clns_pkg::POS_W-1:0] pos_eff;

	assign req.ready = !queue_full;
	assign push      = req.valid && !queue_full;
	assign pos_eff   = req.string_start ? '0 : pos_q;

	always_comb begin
		push_desc.op         = clns_pkg::op_t'(req.op);
		push_desc.byte_value = req.byte_value;
		push_desc.line_break = (clns_pkg::op_t'(req.op) == clns_pkg::OP_STRING)
			&& (pos_eff == line_length);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push && clns_pkg::op_t'(req.op) == clns_pkg::OP_STRING) begin
			pos_q <= (pos_eff == clns_pkg::POS_MAX) ? pos_eff : pos_eff + 1'b1;
		end
	end

endmodule
`default_nettype wire

// ----- sv/clns_queue.sv -----
// Short descriptor queue between the front end and the nibble sequencer.
// Depends on clns_pkg.
`default_nettype none
module clns_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  clns_pkg::desc_t      push_desc,
	output logic                 full,
	input  wire logic            pop,
	output clns_pkg::desc_t      head,
	output logic                 empty
);

	clns_pkg::desc_t mem_q [clns_pkg::QUEUE_DEPTH];
	logic [clns_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [clns_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [clns_pkg::QUEUE_PTR_W:0]   count_q;

	assign full  = (count_q == (clns_pkg::QUEUE_PTR_W+1)'(clns_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/clns_back.sv -----
// Back end: walks each queued descriptor into the result register, one nibble per cycle unless res.ready stalls it.
// Depends on clns_pkg and clns_ifs.
`default_nettype none
module clns_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  clns_pkg::cfg_t   cfg,
	input  clns_pkg::desc_t  head,
	input  wire logic        empty,
	output logic             pop,
	clns_res_if.source       res
);

	logic [clns_pkg::NIB_IDX_W-1:0] idx_q;
	logic [clns_pkg::NIB_IDX_W-1:0] idx_last;
	logic                           valid_q;
	logic                           rs_q;
	logic [3:0]                     nibble_q;
	logic [7:0]                     wait_q;
	logic                           last_q;
	logic                           advance;
	logic                           is_last;
	logic                           rs_d;
	logic [7:0]                     byte_d;
	logic [7:0]                     wait_d;

	always_comb begin
		idx_last = clns_pkg::NIB_LAST_BYTE;
		rs_d     = 1'b0;
		byte_d   = head.byte_value;
		wait_d   = '0;
		case (head.op)
			clns_pkg::OP_STARTUP: begin
				idx_last = clns_pkg::NIB_LAST_STARTUP;
				byte_d   = clns_pkg::STARTUP_CMDS[idx_q[2:1]];
				if (idx_q == 3'd0) begin
					wait_d = cfg.power_up_wait_ms;
				end else if (idx_q == 3'd2) begin
					wait_d = clns_pkg::STARTUP_SECOND_WAIT_MS;
				end
			end
			clns_pkg::OP_COMMAND: begin
				rs_d = 1'b0;
			end
			clns_pkg::OP_DATA: begin
				rs_d = 1'b1;
			end
			clns_pkg::OP_STRING: begin
				if (head.line_break) begin
					idx_last = clns_pkg::NIB_LAST_BREAK;
				end
				if (head.line_break && !idx_q[1]) begin
					byte_d = cfg.second_line_command;
				end else begin
					rs_d = 1'b1;
				end
			end
			default: begin
				rs_d = 1'b0;
			end
		endcase
	end

	assign is_last = (idx_q == idx_last);
	assign advance = !empty && (!valid_q || res.ready);
	assign pop     = advance && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (advance) begin
				valid_q <= 1'b1;
				idx_q   <= is_last ? '0 : idx_q + 1'b1;
			end else if (res.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rs_q     <= rs_d;
			nibble_q <= idx_q[0] ? byte_d[3:0] : byte_d[7:4];
			wait_q   <= wait_d;
			last_q   <= is_last;
		end
	end

	assign res.valid          = valid_q;
	assign res.rs             = rs_q;
	assign res.nibble         = nibble_q;
	assign res.wait_before_ms = wait_q;
	assign res.last           = last_q;

endmodule
`default_nettype wire

// ----- sv/char_lcd_nibble_sequencer.sv -----
// Top level of the character LCD nibble sequencer: register file, front, queue, back.
// Depends on clns_pkg, clns_ifs, clns_front, clns_queue and clns_back.
// An accepted request is first written into the queue; its first nibble is then registered in the result register.
// Nibbles leave at one per cycle while the result channel is ready; a request yields 2, 4 or 8 nibbles by kind.
// A four-entry queue lets requests be taken while earlier ones are still being sent.
// Reset clears the string position and restores register defaults; no clearing pass.
`default_nettype none
module char_lcd_nibble_sequencer (
	input  wire logic   clk,
	input  wire logic   arst_n,
	clns_req_if.sink    req,
	clns_res_if.source  res,
	clns_cfg_if.sink    cfg
);

	clns_pkg::cfg_t  cfg_q;
	clns_pkg::desc_t push_desc;
	clns_pkg::desc_t head;
	logic            push;
	logic            pop;
	logic            full;
	logic            empty;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.power_up_wait_ms    <= clns_pkg::RST_POWER_UP_WAIT;
			cfg_q.line_length         <= clns_pkg::RST_LINE_LENGTH;
			cfg_q.second_line_command <= clns_pkg::RST_SECOND_LINE;
		end else if (cfg.valid) begin
			case (cfg.index)
				clns_pkg::REG_POWER_UP_WAIT: cfg_q.power_up_wait_ms <= cfg.value;
				clns_pkg::REG_LINE_LENGTH: begin
					cfg_q.line_length <= cfg.value[clns_pkg::POS_W-1:0];
				end
				clns_pkg::REG_SECOND_LINE: cfg_q.second_line_command <= cfg.value;
				default: begin
				end
			endcase
		end
	end

	clns_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.line_length (cfg_q.line_length),
		.queue_full  (full),
		.push        (push),
		.push_desc   (push_desc)
	);

	clns_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	clns_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.res    (res)
	);

endmodule
`default_nettype wire

// ----- tb/char_lcd_nibble_sequencer_chk.sv -----
// Checker for the character LCD nibble sequencer: watches the request, nibble and register
// channels, predicts every nibble of each request and compares them in order.
// Depends on clns_pkg for the operation codes and register indexes.
module char_lcd_nibble_sequencer_chk (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_ready,
	input  logic [1:0] req_op,
	input  logic [7:0] req_byte,
	input  logic       req_start,
	input  logic       res_valid,
	input  logic       res_ready,
	input  logic       res_rs,
	input  logic [3:0] res_nibble,
	input  logic [7:0] res_wait,
	input  logic       res_last,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [7:0] cfg_index,
	input  logic [7:0] cfg_value,
	output int         fail_count,
	output int         pending,
	output int         nibbles_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [5:0] POSITION_CEIL = 6'd63;
	localparam logic [7:0] STARTUP_PAUSE_MS = 8'd1;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic       rs;
		logic [3:0] nibble;
		logic [7:0] wait_ms;
		logic       last;
	} lcd_nibble_t;

	lcd_nibble_t expected_nibbles[$];
	logic [7:0] hold_ms;
	logic [7:0] power_wait_ms;
	logic [5:0] line_len;
	logic [7:0] line2_cmd;
	logic [5:0] position;
	int fails;
	int reports;
	int checked;

	function automatic logic [7:0] startup_byte(input int i);
		case (i)
			0: return 8'h33;
			1: return 8'h32;
			2: return 8'h0C;
			default: return 8'h01;
		endcase
	endfunction

	task automatic push_byte(input logic rs, input logic [7:0] b, input logic [7:0] wait_ms,
			input logic ends_request);
		lcd_nibble_t n;
		n.rs = rs;
		n.nibble = b[7:4];
		n.wait_ms = wait_ms;
		n.last = 1'b0;
		expected_nibbles.push_back(n);
		n.nibble = b[3:0];
		n.wait_ms = 8'd0;
		n.last = ends_request;
		expected_nibbles.push_back(n);
	endtask

	task automatic predict_request(input logic [1:0] op_bits, input logic [7:0] b,
			input logic start);
		int i;
		case (clns_pkg::op_t'(op_bits))
			clns_pkg::OP_STARTUP: begin
				for (i = 0; i < 4; i++)
					push_byte(1'b0, startup_byte(i),
						(i == 0) ? power_wait_ms : ((i == 1) ? STARTUP_PAUSE_MS : 8'd0), i == 3);
			end
			clns_pkg::OP_COMMAND: begin
				push_byte(1'b0, b, 8'd0, 1'b1);
			end
			clns_pkg::OP_DATA: begin
				push_byte(1'b1, b, 8'd0, 1'b1);
			end
			default: begin
				if (start)
					position = 6'd0;
				if (position == line_len)
					push_byte(1'b0, line2_cmd, 8'd0, 1'b0);
				push_byte(1'b1, b, 8'd0, 1'b1);
				if (position != POSITION_CEIL)
					position = position + 6'd1;
			end
		endcase
	endtask

	task automatic check_nibble();
		lcd_nibble_t want;
		checked++;
		if (expected_nibbles.size() == 0) begin
			fails++;
			if (reports < REPORT_LIMIT) begin
				reports++;
				$display("%0t: nibble with none predicted: rs %0b nibble %h wait %0d last %0b",
					$time, res_rs, res_nibble, res_wait, res_last);
			end
		end else begin
			want = expected_nibbles.pop_front();
			if (want.rs !== res_rs || want.nibble !== res_nibble ||
					want.wait_ms !== res_wait || want.last !== res_last) begin
				fails++;
				if (reports < REPORT_LIMIT) begin
					reports++;
					$display({"%0t: nibble mismatch (expected/actual): ",
						"rs %0b/%0b nibble %h/%h wait %0d/%0d last %0b/%0b"},
						$time, want.rs, res_rs, want.nibble, res_nibble,
						want.wait_ms, res_wait, want.last, res_last);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ms = 8'd20;
			power_wait_ms = 8'd20;
			line_len = 6'd16;
			line2_cmd = 8'hC0;
			position = 6'd0;
			expected_nibbles.delete();
			fails = 0;
			reports = 0;
			checked = 0;
			fail_count <= 0;
			pending <= 0;
			nibbles_checked <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					clns_pkg::REG_ENABLE_HOLD:   hold_ms = cfg_value;
					clns_pkg::REG_POWER_UP_WAIT: power_wait_ms = cfg_value;
					clns_pkg::REG_LINE_LENGTH:   line_len = cfg_value[5:0];
					clns_pkg::REG_SECOND_LINE:   line2_cmd = cfg_value;
					default: ;
				endcase
			end
			if (req_valid && req_ready)
				predict_request(req_op, req_byte, req_start);
			if (res_valid && res_ready)
				check_nibble();
			fail_count <= fails;
			pending <= expected_nibbles.size();
			nibbles_checked <= checked;
		end
	end

endmodule

// ----- tb/char_lcd_nibble_sequencer_tb.sv -----
// Top of the testbench for the character LCD nibble sequencer: clock, reset, requests,
// register writes and random idling on both sides; the verdict comes from the checker.
// Depends on clns_pkg, clns_ifs, char_lcd_nibble_sequencer and char_lcd_nibble_sequencer_chk.
module char_lcd_nibble_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;

	logic clk;
	logic arst_n;
	int fail_count;
	int pending;
	int nibbles_checked;
	int idle_mode;
	int quiet_cycles;
	int settings_used;
	int requests_by_op[4];

	clns_req_if req_ch();
	clns_res_if res_ch();
	clns_cfg_if cfg_ch();

	char_lcd_nibble_sequencer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	char_lcd_nibble_sequencer_chk u_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_ch.valid),
		.req_ready       (req_ch.ready),
		.req_op          (req_ch.op),
		.req_byte        (req_ch.byte_value),
		.req_start       (req_ch.string_start),
		.res_valid       (res_ch.valid),
		.res_ready       (res_ch.ready),
		.res_rs          (res_ch.rs),
		.res_nibble      (res_ch.nibble),
		.res_wait        (res_ch.wait_before_ms),
		.res_last        (res_ch.last),
		.cfg_valid       (cfg_ch.valid),
		.cfg_ready       (cfg_ch.ready),
		.cfg_index       (cfg_ch.index),
		.cfg_value       (cfg_ch.value),
		.fail_count      (fail_count),
		.pending         (pending),
		.nibbles_checked (nibbles_checked)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int draw_pause();
		case (idle_mode)
			0: return 0;
			1: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
			default: return $urandom_range(0, 14);
		endcase
	endfunction

	task automatic send(input clns_pkg::op_t op, input logic [7:0] b, input logic start);
		int gap;
		gap = draw_pause();
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.byte_value <= b;
		req_ch.string_start <= start;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		requests_by_op[int'(op)]++;
	endtask

	task automatic send_string(input int len);
		int k;
		for (k = 0; k < len; k++)
			send(clns_pkg::OP_STRING, 8'($urandom_range(0, 255)), k == 0);
	endtask

	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input logic [7:0] index, input logic [7:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.value <= value;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
	endtask

	task automatic write_all(input logic [7:0] hold, input logic [7:0] power_wait,
			input logic [7:0] len, input logic [7:0] line2);
		wait_idle();
		write_reg(clns_pkg::REG_ENABLE_HOLD, hold);
		write_reg(clns_pkg::REG_POWER_UP_WAIT, power_wait);
		write_reg(clns_pkg::REG_LINE_LENGTH, len);
		write_reg(clns_pkg::REG_SECOND_LINE, line2);
		write_reg(8'($urandom_range(4, 255)), 8'($urandom_range(0, 255)));
		cfg_ch.valid <= 1'b0;
		settings_used++;
		idle_mode = $urandom_range(0, 2);
	endtask

	task automatic random_phase(input int n_items);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 14) == 0)
				idle_mode = $urandom_range(0, 2);
			case ($urandom_range(0, 9))
				0: begin
					send(clns_pkg::OP_STARTUP, 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
					sent++;
				end
				1, 2: begin
					send(clns_pkg::OP_COMMAND, 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
					sent++;
				end
				3, 4: begin
					send(clns_pkg::OP_DATA, 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
					sent++;
				end
				5: begin
					send(clns_pkg::OP_STRING, 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
					sent++;
				end
				default: begin
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70)
						: $urandom_range(1, 20);
					send_string(len);
					sent += len;
				end
			endcase
			if ($urandom_range(0, 29) == 0)
				wait_idle();
		end
	endtask

	initial begin
		int pause;
		res_ch.ready = 1'b0;
		@(posedge clk iff arst_n === 1'b1);
		forever begin
			pause = draw_pause();
			if (pause != 0) begin
				res_ch.ready <= 1'b0;
				repeat (pause) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (res_ch.valid !== 1'b1);
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles, %0d nibbles still due",
				WATCHDOG_LIMIT, pending);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		quiet_cycles = 0;
		settings_used = 1;
		idle_mode = 0;
		foreach (requests_by_op[i])
			requests_by_op[i] = 0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op = clns_pkg::OP_STARTUP;
		req_ch.byte_value = 8'h00;
		req_ch.string_start = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = clns_pkg::REG_ENABLE_HOLD;
		cfg_ch.value = 8'h00;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: every kind of request, byte extremes, and a string that wraps.
		send(clns_pkg::OP_STARTUP, 8'hA5, 1'b1);
		send(clns_pkg::OP_COMMAND, 8'h00, 1'b0);
		send(clns_pkg::OP_COMMAND, 8'hFF, 1'b1);
		send(clns_pkg::OP_DATA, 8'h00, 1'b1);
		send(clns_pkg::OP_DATA, 8'hFF, 1'b0);
		send_string(17);
		send(clns_pkg::OP_STRING, 8'h41, 1'b1);
		wait_idle();

		write_all(8'd0, 8'd0, 8'h40, 8'h00);
		random_phase(45);
		write_all(8'd255, 8'd255, 8'h3F, 8'hFF);
		send_string(70);
		random_phase(45);
		write_all(8'd1, 8'd1, 8'd1, 8'h80);
		random_phase(45);
		write_all(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd40,
			8'($urandom_range(0, 255)));
		random_phase(45);
		write_all(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		random_phase(45);
		write_all(8'd20, 8'd20, 8'd16, 8'hC0);
		random_phase(45);

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display({"Covered %0d requests (start-up %0d, command %0d, data %0d, ",
			"string %0d) under %0d register settings."},
			requests_by_op[0] + requests_by_op[1] + requests_by_op[2] + requests_by_op[3],
			requests_by_op[0], requests_by_op[1], requests_by_op[2], requests_by_op[3],
			settings_used);
		$display("Compared %0d nibbles with the prediction; %0d failed.",
			nibbles_checked, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
